// File: rtl/swed_pkg.sv
// Shared types and constants for the sliding window extrema detector.
package swed_pkg;

  // Largest half-width the window supports, and the resulting window depth.
  localparam int MAX_HALF_WINDOW = 16;
  localparam int WIN_DEPTH       = 2 * MAX_HALF_WINDOW + 1;

  // Field widths.
  localparam int SAMPLE_W       = 32;
  localparam int CFG_W          = 5;
  localparam int INDEX_BITS     = 24;
  localparam int SAMPLE_INDEX_W = 24;

  // Centre position (0..MAX_HALF_WINDOW) and window position (0..WIN_DEPTH-1).
  localparam int POS_W  = $clog2(MAX_HALF_WINDOW + 1);
  localparam int SPAN_W = $clog2(WIN_DEPTH);

  // Classification codes.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MIN  = 2'd1,
    KIND_MAX  = 2'd2
  } kind_t;

  // Input transaction payload.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_stream;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [SAMPLE_INDEX_W-1:0] sample_index;
    kind_t                     kind;
    logic                      last_of_run;
  } out_item_t;

  // Window storage, entry 0 is the newest sample.
  typedef logic [WIN_DEPTH-1:0][SAMPLE_W-1:0] win_t;

  // Control from the sequencer to the window.
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

endpackage

// File: rtl/swed_window.sv
// Sample window shift register with per-entry valid bits and the stream sample counter.
module swed_window
  import swed_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  win_ctrl_t                  ctrl,
  input  logic [SAMPLE_W-1:0]        sample,
  output win_t                       win,
  output logic [WIN_DEPTH-1:0]       vld,
  output logic [INDEX_BITS-1:0]      seen
);

  win_t                  win_r, win_nxt;
  logic [WIN_DEPTH-1:0]  vld_r, vld_nxt;
  logic [INDEX_BITS-1:0] seen_r, seen_nxt;

  // Next window contents: shift a new sample in, or drop the whole stream.
  always_comb begin
    win_nxt  = win_r;
    vld_nxt  = vld_r;
    seen_nxt = seen_r;
    if (ctrl.clear) begin
      vld_nxt  = '0;
      seen_nxt = '0;
    end else if (ctrl.shift) begin
      win_nxt  = {win_r[WIN_DEPTH-2:0], sample};
      vld_nxt  = {vld_r[WIN_DEPTH-2:0], 1'b1};
      seen_nxt = seen_r + INDEX_BITS'(1);
    end
  end

  // Sample data needs no reset; invalid entries are never used.
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      seen_r <= '0;
    end else begin
      vld_r  <= vld_nxt;
      seen_r <= seen_nxt;
    end
  end

  assign win  = win_r;
  assign vld  = vld_r;
  assign seen = seen_r;

endmodule

// File: rtl/swed_classify.sv
// Parallel comparison of the centre sample against its window neighbors.
module swed_classify
  import swed_pkg::*;
(
  input  win_t                 win,
  input  logic [WIN_DEPTH-1:0] vld,
  input  logic [POS_W-1:0]     cur,
  input  logic [POS_W-1:0]     half,
  output kind_t                kind
);

  logic [SAMPLE_W-1:0]  centre;
  logic [SPAN_W-1:0]    reach;
  logic [WIN_DEPTH-1:0] newer;
  logic [WIN_DEPTH-1:0] older;
  logic [WIN_DEPTH-1:0] lt;
  logic [WIN_DEPTH-1:0] eq;
  logic [WIN_DEPTH-1:0] gt;
  logic                 min_fail;
  logic                 max_fail;

  // One comparator per window entry; newer entries need only be strict,
  // older entries (up to the half-width and while valid) also fail on ties.
  always_comb begin
    centre = win[cur];
    reach  = SPAN_W'(cur) + SPAN_W'(half);
    for (int j = 0; j < WIN_DEPTH; j++) begin
      newer[j] = SPAN_W'(j) < SPAN_W'(cur);
      older[j] = (SPAN_W'(j) > SPAN_W'(cur)) && (SPAN_W'(j) <= reach) && vld[j];
      lt[j]    = $signed(win[j]) < $signed(centre);
      eq[j]    = win[j] == centre;
      gt[j]    = !lt[j] && !eq[j];
    end
    min_fail = |((newer & lt) | (older & (lt | eq)));
    max_fail = |((newer & gt) | (older & (gt | eq)));
  end

  // A minimum wins over a maximum.
  always_comb begin
    if (!min_fail) begin
      kind = KIND_MIN;
    end else if (!max_fail) begin
      kind = KIND_MAX;
    end else begin
      kind = KIND_NONE;
    end
  end

endmodule

// File: rtl/sliding_window_extrema_detector.sv
// Top level of the sliding window extrema detector.
//
// Samples enter on the in_ channel (valid/ready) and one result per sample
// leaves on the out_ channel (valid/ready): its index in the stream, its kind
// (neither, local minimum, local maximum) and a last-of-run flag. cfg_we with
// cfg_wdata sets the half-width, values above 16 act as 16.
// A sample is classified once half-width later samples have arrived. Each
// accepted transaction shifts the window register; the centre entry is then
// compared against all 32 neighbors in parallel and the result is loaded into
// the output register once that register is free. One sample is taken every
// cycle in steady state while the receiver accepts results.
// An end-of-stream sample starts a flush that emits the remaining
// half-width + 1 results at one per cycle unless the receiver stalls, set by
// the single output register; input is held off during the flush and for the
// cycle that clears the window. When the receiver stalls, the output register
// holds its result and input stops once the pending result cannot advance.
// Reset empties the window, clears the sample count and sets the half-width to 1.
module sliding_window_extrema_detector
  import swed_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0]      hw_r, hw_nxt;
  logic                  pend_r, pend_nxt;
  logic                  flush_r, flush_nxt;
  logic [POS_W-1:0]      cur_r, cur_nxt;
  logic                  out_vld_r, out_vld_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [POS_W-1:0]      half;
  win_t                  win;
  logic [WIN_DEPTH-1:0]  vld;
  logic [INDEX_BITS-1:0] seen;
  logic [INDEX_BITS-1:0] pos;
  kind_t                 kind;
  win_ctrl_t             wctrl;
  logic                  cur_vld;
  logic                  out_free;
  logic                  step_go;
  logic                  emit;
  logic                  last_step;
  logic                  job_done;
  logic                  accept;

  // Effective half-width.
  always_comb begin
    if (32'(hw_r) > 32'(MAX_HALF_WINDOW)) begin
      half = POS_W'(MAX_HALF_WINDOW);
    end else begin
      half = POS_W'(hw_r);
    end
  end

  // Handshake and sequencing of the pending centre positions.
  always_comb begin
    cur_vld     = vld[cur_r];
    out_free    = !out_vld_r || out_ready;
    step_go     = pend_r && (!cur_vld || out_free);
    emit        = step_go && cur_vld;
    last_step   = !flush_r || (cur_r == '0);
    job_done    = step_go && last_step;
    in_ready    = !pend_r || (job_done && !flush_r);
    accept      = in_valid && in_ready;
    wctrl.shift = accept;
    wctrl.clear = job_done && flush_r;
  end

  swed_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (wctrl),
    .sample (in_data.sample),
    .win    (win),
    .vld    (vld),
    .seen   (seen)
  );

  swed_classify u_classify (
    .win  (win),
    .vld  (vld),
    .cur  (cur_r),
    .half (half),
    .kind (kind)
  );

  // Stream position of the centre sample.
  assign pos = seen - INDEX_BITS'(1) - INDEX_BITS'(cur_r);

  // Next-state logic for the sequencer, the configuration and the output register.
  always_comb begin
    hw_nxt       = cfg_we ? cfg_wdata : hw_r;
    pend_nxt     = pend_r;
    flush_nxt    = flush_r;
    cur_nxt      = cur_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    if (accept) begin
      pend_nxt  = 1'b1;
      flush_nxt = in_data.end_of_stream;
      cur_nxt   = half;
    end else if (job_done) begin
      pend_nxt = 1'b0;
    end else if (step_go) begin
      cur_nxt = cur_r - POS_W'(1);
    end
    if (emit) begin
      out_vld_nxt               = 1'b1;
      out_data_nxt.sample_index = SAMPLE_INDEX_W'(pos);
      out_data_nxt.kind         = kind;
      out_data_nxt.last_of_run  = flush_r && (cur_r == '0);
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r      <= CFG_W'(1);
      pend_r    <= 1'b0;
      flush_r   <= 1'b0;
      cur_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      hw_r      <= hw_nxt;
      pend_r    <= pend_nxt;
      flush_r   <= flush_nxt;
      cur_r     <= cur_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/swed_checker.sv
// Port-level assertions for the sliding window extrema detector, bound to the top level.
module swed_checker
  import swed_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input in_item_t         in_data,
  input logic             out_valid,
  input logic             out_ready,
  input out_item_t        out_data
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An end-of-stream transaction starts a flush that holds off input.
  a_flush_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.end_of_stream |=> !in_ready)
    else $error("input accepted during flush");

endmodule

bind sliding_window_extrema_detector swed_checker u_swed_checker (.*);
